/* rtl/cpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Closest point on triangle: shared package
// Widths, types and region codes used by the closest point unit, its
// divider pipeline and its channel interfaces.
// ----------------------------------------------------------------------------
package cpt_pkg;

  // Coordinate width (signed fixed point) and fraction bits of a weight.
  localparam int COORD_WIDTH = 16;
  localparam int WEIGHT_FRAC = 16;

  // Derived widths.
  localparam int CW  = COORD_WIDTH;
  localparam int DFW = CW + 1;           // difference of two coordinates
  localparam int DPW = 2 * DFW;          // product of two differences
  localparam int DW  = DPW + 2;          // dot product of three terms
  localparam int HW  = DW / 2;           // low half of a dot product
  localparam int HI  = DW - HW;          // high half of a dot product
  localparam int PPW = 2 * DW;           // product of two dot products
  localparam int VW  = PPW + 2;          // area terms and their sum
  localparam int DVW = VW - 1;           // unsigned divider width
  localparam int WW  = WEIGHT_FRAC + 1;  // weight, 1.0 included
  localparam int EPW = DFW + WW + 1;     // edge times weight
  localparam int TW  = EPW + 2;          // closest point before rounding
  localparam int SHW = TW - WEIGHT_FRAC; // closest point after the shift

  typedef logic signed [CW-1:0]      coord_t;
  typedef logic signed [DFW-1:0]     dif_t;
  typedef logic signed [DPW-1:0]     dprod_t;
  typedef logic signed [DW-1:0]      dot_t;
  typedef logic signed [VW-1:0]      vol_t;
  typedef logic [DVW-1:0]            rem_t;
  typedef logic [WEIGHT_FRAC-1:0]    quo_t;
  typedef logic [WW-1:0]             wgt_t;

  localparam wgt_t W_ONE = {1'b1, {WEIGHT_FRAC{1'b0}}};

  // Region codes, in the order in which the regions are tested.
  typedef enum logic [2:0] {
    RG_VERT_A  = 3'd0,
    RG_VERT_B  = 3'd1,
    RG_EDGE_AB = 3'd2,
    RG_VERT_C  = 3'd3,
    RG_EDGE_AC = 3'd4,
    RG_EDGE_BC = 3'd5,
    RG_FACE    = 3'd6
  } region_e;

  // What travels beside the divider: base point, edges, region, the divisor
  // flag and the clamp flags of the two quotients.
  typedef struct packed {
    coord_t [2:0] base;
    dif_t   [2:0] e1;
    dif_t   [2:0] e2;
    region_e      region;
    logic         den_ok;
    logic         zero1;
    logic         full1;
    logic         zero2;
    logic         full2;
  } geo_t;

  // Divider state: shared divisor, two partial remainders and quotients.
  typedef struct packed {
    rem_t den;
    rem_t rem1;
    rem_t rem2;
    quo_t q1;
    quo_t q2;
  } div_t;

endpackage
`default_nettype wire

/* rtl/cpt_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Closest point on triangle: input channel
// One word holds a query point and the three triangle vertices.
// ----------------------------------------------------------------------------
interface cpt_in_if;
  logic            valid;
  logic            ready;
  cpt_pkg::coord_t point_x;
  cpt_pkg::coord_t point_y;
  cpt_pkg::coord_t point_z;
  cpt_pkg::coord_t vert_a_x;
  cpt_pkg::coord_t vert_a_y;
  cpt_pkg::coord_t vert_a_z;
  cpt_pkg::coord_t vert_b_x;
  cpt_pkg::coord_t vert_b_y;
  cpt_pkg::coord_t vert_b_z;
  cpt_pkg::coord_t vert_c_x;
  cpt_pkg::coord_t vert_c_y;
  cpt_pkg::coord_t vert_c_z;

  modport source (
    output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/cpt_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Closest point on triangle: result channel
// One word holds the closest point, the three weights and the region code.
// ----------------------------------------------------------------------------
interface cpt_out_if;
  logic            valid;
  logic            ready;
  cpt_pkg::coord_t near_x;
  cpt_pkg::coord_t near_y;
  cpt_pkg::coord_t near_z;
  cpt_pkg::wgt_t   weight_a;
  cpt_pkg::wgt_t   weight_b;
  cpt_pkg::wgt_t   weight_c;
  logic [2:0]      region;

  modport source (
    output valid, near_x, near_y, near_z, weight_a, weight_b, weight_c, region,
    input  ready
  );
  modport sink (
    input  valid, near_x, near_y, near_z, weight_a, weight_b, weight_c, region,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/closest_point_on_triangle_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Closest point on triangle unit
// Voronoi region classification of a query point against a triangle, with
// closest point, barycentric weights and region code.
// ----------------------------------------------------------------------------
// The unit takes one word per clock unless the result channel stalls, and
// gives one result word per word, in order, through 8 + WEIGHT_FRAC + 3
// stages: eight stages form the edge differences, the six dot products, the
// area terms (as split partial products), the region and the clamped division
// operands; the weight divider takes one stage per quotient bit; three stages
// form the weights, the edge-times-weight products and the rounded, saturated
// point. Every stage has its own valid bit and loads whenever it is empty or
// its successor moves on, so empty stages close up while the result waits.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpt_in_if.sink    in_i,
  cpt_out_if.source out_o
);
  import cpt_pkg::*;

  typedef struct packed {
    coord_t [2:0] a;
    coord_t [2:0] b;
    coord_t [2:0] c;
    dif_t   [2:0] ab;
    dif_t   [2:0] ac;
    dif_t   [2:0] bc;
  } tri_t;

  // Operands of the six area products: vc = P0-P1, vb = P2-P3, va = P4-P5.
  localparam int OPX [6] = '{0, 2, 4, 0, 2, 4};
  localparam int OPY [6] = '{3, 1, 1, 5, 5, 3};

  // Stage enables and valid bits.
  logic en0, en1, en2, en3, en4, en5, en6, en7, en_w, en_p, en_o;
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, vw_q, vp_q, vo_q;
  logic div_ready, div_valid;

  assign en_o = !vo_q || out_o.ready;
  assign en_p = !vp_q || en_o;
  assign en_w = !vw_q || en_p;
  assign en7  = !v7_q || div_ready;
  assign en6  = !v6_q || en7;
  assign en5  = !v5_q || en6;
  assign en4  = !v4_q || en5;
  assign en3  = !v3_q || en4;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;
  assign en0  = !v0_q || en1;
  assign in_i.ready = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      vw_q <= 1'b0;
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en0)  v0_q <= in_i.valid;
      if (en1)  v1_q <= v0_q;
      if (en2)  v2_q <= v1_q;
      if (en3)  v3_q <= v2_q;
      if (en4)  v4_q <= v3_q;
      if (en5)  v5_q <= v4_q;
      if (en6)  v6_q <= v5_q;
      if (en7)  v7_q <= v6_q;
      if (en_w) vw_q <= div_valid;
      if (en_p) vp_q <= vw_q;
      if (en_o) vo_q <= vp_q;
    end
  end

  // Stage 0: vertices and all coordinate differences.
  coord_t [2:0] in_p, in_a, in_b, in_c;
  tri_t         tri0_q;
  dif_t   [2:0] ap0_q, bp0_q, cp0_q;

  assign in_p = {in_i.point_z, in_i.point_y, in_i.point_x};
  assign in_a = {in_i.vert_a_z, in_i.vert_a_y, in_i.vert_a_x};
  assign in_b = {in_i.vert_b_z, in_i.vert_b_y, in_i.vert_b_x};
  assign in_c = {in_i.vert_c_z, in_i.vert_c_y, in_i.vert_c_x};

  always_ff @(posedge clk_i) begin
    if (en0) begin
      tri0_q.a <= in_a;
      tri0_q.b <= in_b;
      tri0_q.c <= in_c;
      for (int i = 0; i < 3; i++) begin
        tri0_q.ab[i] <= dif_t'($signed(in_b[i])) - dif_t'($signed(in_a[i]));
        tri0_q.ac[i] <= dif_t'($signed(in_c[i])) - dif_t'($signed(in_a[i]));
        tri0_q.bc[i] <= dif_t'($signed(in_c[i])) - dif_t'($signed(in_b[i]));
        ap0_q[i]     <= dif_t'($signed(in_p[i])) - dif_t'($signed(in_a[i]));
        bp0_q[i]     <= dif_t'($signed(in_p[i])) - dif_t'($signed(in_b[i]));
        cp0_q[i]     <= dif_t'($signed(in_p[i])) - dif_t'($signed(in_c[i]));
      end
    end
  end

  // Stage 1: the eighteen coordinate products of the dot products.
  dif_t   [2:0] edg0 [2];
  dif_t   [2:0] vpt0 [3];
  dprod_t [2:0] pr1_q [6];
  tri_t         tri1_q;

  assign edg0[0] = tri0_q.ab;
  assign edg0[1] = tri0_q.ac;
  assign vpt0[0] = ap0_q;
  assign vpt0[1] = bp0_q;
  assign vpt0[2] = cp0_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      tri1_q <= tri0_q;
      for (int j = 0; j < 3; j++) begin
        for (int e = 0; e < 2; e++) begin
          for (int i = 0; i < 3; i++) begin
            pr1_q[2*j+e][i] <= $signed(edg0[e][i]) * $signed(vpt0[j][i]);
          end
        end
      end
    end
  end

  // Stage 2: d1..d6 (held at index 0..5).
  dot_t d2_q [6];
  tri_t tri2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      tri2_q <= tri1_q;
      for (int k = 0; k < 6; k++) begin
        d2_q[k] <= dot_t'($signed(pr1_q[k][0])) + dot_t'($signed(pr1_q[k][1]))
                 + dot_t'($signed(pr1_q[k][2]));
      end
    end
  end

  // Stage 3: split partial products of the six area products.
  logic signed [2*HI-1:0] hh3_q [6];
  logic signed [HI+HW:0]  hl3_q [6];
  logic signed [HI+HW:0]  lh3_q [6];
  logic [2*HW-1:0]        ll3_q [6];
  dot_t                   d3_q  [6];
  tri_t                   tri3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      tri3_q <= tri2_q;
      d3_q   <= d2_q;
      for (int k = 0; k < 6; k++) begin
        hh3_q[k] <= $signed(d2_q[OPX[k]][DW-1:HW]) * $signed(d2_q[OPY[k]][DW-1:HW]);
        hl3_q[k] <= $signed(d2_q[OPX[k]][DW-1:HW])
                  * $signed({1'b0, d2_q[OPY[k]][HW-1:0]});
        lh3_q[k] <= $signed({1'b0, d2_q[OPX[k]][HW-1:0]})
                  * $signed(d2_q[OPY[k]][DW-1:HW]);
        ll3_q[k] <= d2_q[OPX[k]][HW-1:0] * d2_q[OPY[k]][HW-1:0];
      end
    end
  end

  // Stage 4: full area products from their partials.
  vol_t prod4_q [6];
  dot_t d4_q    [6];
  tri_t tri4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      tri4_q <= tri3_q;
      d4_q   <= d3_q;
      for (int k = 0; k < 6; k++) begin
        prod4_q[k] <= (vol_t'(hh3_q[k]) <<< (2 * HW))
                    + ((vol_t'(hl3_q[k]) + vol_t'(lh3_q[k])) <<< HW)
                    + vol_t'(ll3_q[k]);
      end
    end
  end

  // Stage 5: area terms vc, vb, va.
  vol_t va5_q, vb5_q, vc5_q;
  dot_t d5_q [6];
  tri_t tri5_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      tri5_q <= tri4_q;
      d5_q   <= d4_q;
      vc5_q  <= prod4_q[0] - prod4_q[1];
      vb5_q  <= prod4_q[2] - prod4_q[3];
      va5_q  <= prod4_q[4] - prod4_q[5];
    end
  end

  // Stage 6: region selection, division operands, base point and edges.
  vol_t    dd1, dd2, dd3, dd4, dd5, dd6, d43, d56;
  vol_t    num1_d, num2_d, den_d;
  geo_t    geo6_d, geo6_q;
  vol_t    num1_6q, num2_6q, den6_q;

  assign dd1 = vol_t'(d5_q[0]);
  assign dd2 = vol_t'(d5_q[1]);
  assign dd3 = vol_t'(d5_q[2]);
  assign dd4 = vol_t'(d5_q[3]);
  assign dd5 = vol_t'(d5_q[4]);
  assign dd6 = vol_t'(d5_q[5]);
  assign d43 = dd4 - dd3;
  assign d56 = dd5 - dd6;

  always_comb begin
    geo6_d        = '0;
    num1_d        = '0;
    num2_d        = '0;
    den_d         = '0;
    geo6_d.base   = tri5_q.a;
    geo6_d.region = RG_FACE;
    priority if (dd1 <= 0 && dd2 <= 0) begin
      geo6_d.region = RG_VERT_A;
    end else if (dd3 >= 0 && dd4 <= dd3) begin
      geo6_d.region = RG_VERT_B;
      geo6_d.base   = tri5_q.b;
    end else if (vc5_q <= 0 && dd1 >= 0 && dd3 <= 0) begin
      geo6_d.region = RG_EDGE_AB;
      geo6_d.e1     = tri5_q.ab;
      num1_d        = dd1;
      den_d         = dd1 - dd3;
    end else if (dd6 >= 0 && dd5 <= dd6) begin
      geo6_d.region = RG_VERT_C;
      geo6_d.base   = tri5_q.c;
    end else if (vb5_q <= 0 && dd2 >= 0 && dd6 <= 0) begin
      geo6_d.region = RG_EDGE_AC;
      geo6_d.e1     = tri5_q.ac;
      num1_d        = dd2;
      den_d         = dd2 - dd6;
    end else if (va5_q <= 0 && d43 >= 0 && d56 >= 0) begin
      geo6_d.region = RG_EDGE_BC;
      geo6_d.base   = tri5_q.b;
      geo6_d.e1     = tri5_q.bc;
      num1_d        = d43;
      den_d         = d43 + d56;
    end else begin
      geo6_d.e1     = tri5_q.ab;
      geo6_d.e2     = tri5_q.ac;
      num1_d        = vb5_q;
      num2_d        = vc5_q;
      den_d         = va5_q + vb5_q + vc5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      geo6_q  <= geo6_d;
      num1_6q <= num1_d;
      num2_6q <= num2_d;
      den6_q  <= den_d;
    end
  end

  // Stage 7: clamp flags and divider start values.
  geo_t geo7_d, geo7_q;
  div_t div7_d, div7_q;

  always_comb begin
    geo7_d        = geo6_q;
    geo7_d.den_ok = den6_q > 0;
    geo7_d.zero1  = num1_6q <= 0;
    geo7_d.full1  = num1_6q >= den6_q;
    geo7_d.zero2  = num2_6q <= 0;
    geo7_d.full2  = num2_6q >= den6_q;
    div7_d        = '0;
    div7_d.den    = den6_q[DVW-1:0];
    div7_d.rem1   = (geo7_d.zero1 || geo7_d.full1) ? '0 : num1_6q[DVW-1:0];
    div7_d.rem2   = (geo7_d.zero2 || geo7_d.full2) ? '0 : num2_6q[DVW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en7) begin
      geo7_q <= geo7_d;
      div7_q <= div7_d;
    end
  end

  // Weight divider.
  quo_t quo1, quo2;
  geo_t geo_dv;

  cpt_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .ready_o (div_ready),
    .div_i   (div7_q),
    .geo_i   (geo7_q),
    .valid_o (div_valid),
    .ready_i (en_w),
    .quo1_o  (quo1),
    .quo2_o  (quo2),
    .geo_o   (geo_dv)
  );

  // Weight stage: clamped quotients become the three weights.
  wgt_t            q1f, q2f;
  logic [WW:0]     qsum;
  wgt_t            wa_d, wb_d, wc_d, w1_d, w2_d;
  wgt_t            wa_q, wb_q, wc_q, w1_q, w2_q;
  geo_t            geow_q;

  assign q1f  = geo_dv.full1 ? W_ONE : (geo_dv.zero1 ? '0 : {1'b0, quo1});
  assign q2f  = geo_dv.full2 ? W_ONE : (geo_dv.zero2 ? '0 : {1'b0, quo2});
  assign qsum = {1'b0, q1f} + {1'b0, q2f};

  always_comb begin
    wa_d = '0;
    wb_d = '0;
    wc_d = '0;
    unique case (geo_dv.region)
      RG_VERT_A: wa_d = W_ONE;
      RG_VERT_B: wb_d = W_ONE;
      RG_VERT_C: wc_d = W_ONE;
      RG_EDGE_AB: begin
        if (geo_dv.den_ok) begin
          wb_d = q1f;
          wa_d = W_ONE - q1f;
        end
      end
      RG_EDGE_AC: begin
        if (geo_dv.den_ok) begin
          wc_d = q1f;
          wa_d = W_ONE - q1f;
        end
      end
      RG_EDGE_BC: begin
        if (geo_dv.den_ok) begin
          wc_d = q1f;
          wb_d = W_ONE - q1f;
        end
      end
      RG_FACE: begin
        if (geo_dv.den_ok) begin
          wb_d = q1f;
          wc_d = (qsum > {1'b0, W_ONE}) ? W_ONE - q1f : q2f;
          wa_d = W_ONE - wb_d - wc_d;
        end
      end
      default: ;
    endcase
    // Weights that scale the edges; the first edge of edge AB is AB.
    unique case (geo_dv.region)
      RG_EDGE_AB, RG_FACE: w1_d = wb_d;
      RG_EDGE_AC, RG_EDGE_BC: w1_d = wc_d;
      default: w1_d = '0;
    endcase
    w2_d = (geo_dv.region == RG_FACE) ? wc_d : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      geow_q <= geo_dv;
      wa_q   <= wa_d;
      wb_q   <= wb_d;
      wc_q   <= wc_d;
      w1_q   <= w1_d;
      w2_q   <= w2_d;
    end
  end

  // Product stage: edge times weight for each axis.
  logic signed [EPW-1:0] pe1_q [3];
  logic signed [EPW-1:0] pe2_q [3];
  coord_t [2:0]          basep_q;
  wgt_t                  wap_q, wbp_q, wcp_q;
  region_e               regp_q;

  always_ff @(posedge clk_i) begin
    if (en_p) begin
      basep_q <= geow_q.base;
      regp_q  <= geow_q.region;
      wap_q   <= wa_q;
      wbp_q   <= wb_q;
      wcp_q   <= wc_q;
      for (int i = 0; i < 3; i++) begin
        pe1_q[i] <= $signed(geow_q.e1[i]) * $signed({1'b0, w1_q});
        pe2_q[i] <= $signed(geow_q.e2[i]) * $signed({1'b0, w2_q});
      end
    end
  end

  // Output stage: round to nearest (ties up) and saturate.
  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
  logic signed [TW-1:0]  tsum [3];
  logic signed [SHW-1:0] tsh  [3];
  coord_t [2:0]          near_d, near_q;
  wgt_t                  wao_q, wbo_q, wco_q;
  region_e               rego_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i] = (TW'($signed(basep_q[i])) <<< WEIGHT_FRAC)
              + TW'(pe1_q[i]) + TW'(pe2_q[i])
              + (TW'(1) <<< (WEIGHT_FRAC - 1));
      tsh[i]  = tsum[i][TW-1:WEIGHT_FRAC];
      if (tsh[i] > SHW'(CMAX)) begin
        near_d[i] = CMAX;
      end else if (tsh[i] < SHW'(CMIN)) begin
        near_d[i] = CMIN;
      end else begin
        near_d[i] = tsh[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      near_q <= near_d;
      wao_q  <= wap_q;
      wbo_q  <= wbp_q;
      wco_q  <= wcp_q;
      rego_q <= regp_q;
    end
  end

  assign out_o.valid    = vo_q;
  assign out_o.near_x   = near_q[0];
  assign out_o.near_y   = near_q[1];
  assign out_o.near_z   = near_q[2];
  assign out_o.weight_a = wao_q;
  assign out_o.weight_b = wbo_q;
  assign out_o.weight_c = wco_q;
  assign out_o.region   = rego_q;

  // Checks on the result word.
  logic [WW+1:0] wsum_chk;
  assign wsum_chk = (WW+2)'(out_o.weight_a) + (WW+2)'(out_o.weight_b)
                  + (WW+2)'(out_o.weight_c);

  // Weights sum to one, or all are zero for a degenerate triangle.
  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (wsum_chk == (WW+2)'(W_ONE)) || (wsum_chk == '0))
    else $error("weights do not sum to one");

  // A vertex A result puts the whole weight on A.
  a_vert_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.region == RG_VERT_A) |-> out_o.weight_a == W_ONE)
    else $error("vertex A result with wrong weight");

  // An edge AB result gives no weight to C.
  a_edge_ab: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.region == RG_EDGE_AB) |-> out_o.weight_c == '0)
    else $error("edge AB result with weight on C");

endmodule
`default_nettype wire

/* rtl/cpt_div_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Closest point on triangle: weight divider
// Restoring division, one quotient bit per stage, two lanes that share one
// divisor. Each stage holds its own valid bit and stalls only when full.
// ----------------------------------------------------------------------------
module cpt_div_pipe (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  cpt_pkg::div_t  div_i,
  input  cpt_pkg::geo_t  geo_i,
  output logic           valid_o,
  input  logic           ready_i,
  output cpt_pkg::quo_t  quo1_o,
  output cpt_pkg::quo_t  quo2_o,
  output cpt_pkg::geo_t  geo_o
);
  import cpt_pkg::*;

  localparam int NS = WEIGHT_FRAC;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  div_t          div_q [NS];
  geo_t          geo_q [NS];

  // One quotient bit for both lanes.
  function automatic div_t div_step(div_t x);
    logic [DVW:0] r1;
    logic [DVW:0] r2;
    div_t         y;
    y  = x;
    r1 = {x.rem1, 1'b0};
    r2 = {x.rem2, 1'b0};
    if (r1 >= {1'b0, x.den}) begin
      y.rem1 = DVW'(r1 - {1'b0, x.den});
      y.q1   = {x.q1[WEIGHT_FRAC-2:0], 1'b1};
    end else begin
      y.rem1 = r1[DVW-1:0];
      y.q1   = {x.q1[WEIGHT_FRAC-2:0], 1'b0};
    end
    if (r2 >= {1'b0, x.den}) begin
      y.rem2 = DVW'(r2 - {1'b0, x.den});
      y.q2   = {x.q2[WEIGHT_FRAC-2:0], 1'b1};
    end else begin
      y.rem2 = r2[DVW-1:0];
      y.q2   = {x.q2[WEIGHT_FRAC-2:0], 1'b0};
    end
    return y;
  endfunction

  // A stage loads when it is empty or when the next one moves on.
  always_comb begin
    en[NS-1] = !v_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Division steps and side data.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      div_q[0] <= div_step(div_i);
      geo_q[0] <= geo_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        div_q[k] <= div_step(div_q[k-1]);
        geo_q[k] <= geo_q[k-1];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign quo1_o  = div_q[NS-1].q1;
  assign quo2_o  = div_q[NS-1].q2;
  assign geo_o   = geo_q[NS-1];

endmodule
`default_nettype wire
